// File: hw/rtl/dtq_pkg.sv
// ----------------------------------------------------------------------------
// Deadline timer queue package
// Shared widths, operation and status codes, and the control word that the
// top level hands to every cell of the sorted timer chain.
// ----------------------------------------------------------------------------
package dtq_pkg;

    // Default sizes of the timer table and of the millisecond clock.
    localparam int DEF_TABLE_DEPTH = 16;
    localparam int DEF_TIME_BITS   = 48;

    // Fixed widths of the interface fields.
    localparam int OP_W     = 2;
    localparam int DELAY_W  = 31;
    localparam int OWNER_W  = 16;
    localparam int DATA_W   = 32;
    localparam int HANDLE_W = 48;
    localparam int STATUS_W = 3;

    // Upper bound on expiries emitted for one tick.
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS);

    // Operation codes of an input item.
    typedef enum logic [OP_W-1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // Status codes of a result item.
    typedef enum logic [STATUS_W-1:0] {
        ST_STARTED   = 3'd0,
        ST_STOPPED   = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FIRED     = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    // What every cell does in a given cycle.
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2,
        CELL_POP    = 2'd3
    } cell_op_t;

    // Control word broadcast along the chain.
    typedef struct packed {
        cell_op_t op;
        logic     key_fits;
    } cell_ctrl_t;

    // Sequencer states of the top level.
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_POP  = 2'd2
    } state_t;

endpackage

// File: hw/rtl/dtq_cell.sv
// ----------------------------------------------------------------------------
// Deadline timer queue cell
// One slot of the sorted timer chain. Each cell holds one entry and, on
// command, keeps it, takes the new entry, or takes its left or right
// neighbour's entry, so that the chain stays compact and in firing order.
// ----------------------------------------------------------------------------
module dtq_cell #(
    parameter int TIME_BITS = dtq_pkg::DEF_TIME_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dtq_pkg::cell_ctrl_t                 ctrl,
    input  logic [TIME_BITS-1:0]                key_deadline,
    input  logic [dtq_pkg::OWNER_W-1:0]         key_owner,
    input  logic signed [dtq_pkg::DATA_W-1:0]   key_data,
    input  logic                                left_valid,
    input  logic [TIME_BITS-1:0]                left_deadline,
    input  logic [dtq_pkg::OWNER_W-1:0]         left_owner,
    input  logic signed [dtq_pkg::DATA_W-1:0]   left_data,
    input  logic                                left_keep,
    input  logic                                right_valid,
    input  logic [TIME_BITS-1:0]                right_deadline,
    input  logic [dtq_pkg::OWNER_W-1:0]         right_owner,
    input  logic signed [dtq_pkg::DATA_W-1:0]   right_data,
    input  logic                                seen_in,
    output logic                                valid,
    output logic [TIME_BITS-1:0]                deadline,
    output logic [dtq_pkg::OWNER_W-1:0]         owner,
    output logic signed [dtq_pkg::DATA_W-1:0]   data,
    output logic                                keep,
    output logic                                seen_out
);

    logic                              valid_reg, valid_next;
    logic [TIME_BITS-1:0]              deadline_reg, deadline_next;
    logic [dtq_pkg::OWNER_W-1:0]       owner_reg, owner_next;
    logic signed [dtq_pkg::DATA_W-1:0] data_reg, data_next;
    logic                              match;

    // An entry stays in place on insertion if it fires no later than the key.
    assign keep = valid_reg && (deadline_reg <= key_deadline);

    // A stop hits this entry if deadline and owner both match and the handle fits.
    assign match    = valid_reg && ctrl.key_fits && (deadline_reg == key_deadline)
                      && (owner_reg == key_owner);
    assign seen_out = seen_in | match;

    // Choose where this slot's next contents come from.
    always_comb
    begin
        valid_next    = valid_reg;
        deadline_next = deadline_reg;
        owner_next    = owner_reg;
        data_next     = data_reg;
        case (ctrl.op)
            dtq_pkg::CELL_INSERT:
            begin
                if (!keep) begin
                    if (left_keep) begin
                        valid_next    = 1'b1;
                        deadline_next = key_deadline;
                        owner_next    = key_owner;
                        data_next     = key_data;
                    end else begin
                        valid_next    = left_valid;
                        deadline_next = left_deadline;
                        owner_next    = left_owner;
                        data_next     = left_data;
                    end
                end
            end
            dtq_pkg::CELL_REMOVE:
            begin
                if (seen_out) begin
                    valid_next    = right_valid;
                    deadline_next = right_deadline;
                    owner_next    = right_owner;
                    data_next     = right_data;
                end
            end
            dtq_pkg::CELL_POP:
            begin
                valid_next    = right_valid;
                deadline_next = right_deadline;
                owner_next    = right_owner;
                data_next     = right_data;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    // Valid bit is control state; the payload needs no reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        deadline_reg <= deadline_next;
        owner_reg    <= owner_next;
        data_reg     <= data_next;
    end

    assign valid    = valid_reg;
    assign deadline = deadline_reg;
    assign owner    = owner_reg;
    assign data     = data_reg;

endmodule

// File: hw/rtl/deadline_timer_queue.sv
// Start and stop: the command is registered, executed in the EXEC state, and the
//   result registered and strobed on done; no new command is taken while in EXEC.
// Tick: up to 16 expiries, one per cycle from the head of the cell chain, once the
//   clock has advanced; busy in the POP state, also when no entry is due.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset clears the clock and all valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
// Deadline timer queue
// Millisecond clock with a table of pending timers held in a chain of cells
// sorted by deadline. Starts insert, stops remove, ticks pop due entries.
// ----------------------------------------------------------------------------
module deadline_timer_queue #(
    parameter int TABLE_DEPTH = dtq_pkg::DEF_TABLE_DEPTH,
    parameter int TIME_BITS   = dtq_pkg::DEF_TIME_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [dtq_pkg::OP_W-1:0]            operation,
    input  logic [dtq_pkg::DELAY_W-1:0]         delay_ms,
    input  logic [dtq_pkg::OWNER_W-1:0]         owner_id,
    input  logic signed [dtq_pkg::DATA_W-1:0]   app_data,
    input  logic [dtq_pkg::HANDLE_W-1:0]        handle,
    output logic                                done,
    output logic [dtq_pkg::STATUS_W-1:0]        status,
    output logic [dtq_pkg::HANDLE_W-1:0]        result_handle,
    output logic [dtq_pkg::OWNER_W-1:0]         fired_owner,
    output logic signed [dtq_pkg::DATA_W-1:0]   fired_data,
    output logic                                last
);

    localparam int CMP_W = (TIME_BITS > dtq_pkg::HANDLE_W) ? TIME_BITS
                                                           : dtq_pkg::HANDLE_W;

    // Sequencer and command registers.
    dtq_pkg::state_t                   state_reg, state_next;
    logic [dtq_pkg::OP_W-1:0]          op_reg, op_next;
    logic [TIME_BITS-1:0]              now_reg, now_next;
    logic [TIME_BITS-1:0]              dl_reg, dl_next;
    logic [dtq_pkg::OWNER_W-1:0]       own_reg, own_next;
    logic signed [dtq_pkg::DATA_W-1:0] dat_reg, dat_next;
    logic [dtq_pkg::HANDLE_W-1:0]      hdl_reg, hdl_next;
    logic [dtq_pkg::CNT_W-1:0]         cnt_reg, cnt_next;

    // Result registers.
    logic                              done_reg, done_next;
    logic [dtq_pkg::STATUS_W-1:0]      status_reg, status_next;
    logic [dtq_pkg::HANDLE_W-1:0]      rhdl_reg, rhdl_next;
    logic [dtq_pkg::OWNER_W-1:0]       rown_reg, rown_next;
    logic signed [dtq_pkg::DATA_W-1:0] rdat_reg, rdat_next;
    logic                              last_reg, last_next;

    // Chain signals.
    dtq_pkg::cell_ctrl_t               ctrl;
    logic [TIME_BITS-1:0]              key_deadline;
    logic                              c_valid    [TABLE_DEPTH];
    logic [TIME_BITS-1:0]              c_deadline [TABLE_DEPTH];
    logic [dtq_pkg::OWNER_W-1:0]       c_owner    [TABLE_DEPTH];
    logic signed [dtq_pkg::DATA_W-1:0] c_data     [TABLE_DEPTH];
    logic [TABLE_DEPTH:0]              keep_chain;
    logic [TABLE_DEPTH:0]              seen_chain;

    logic                              accept;
    logic [CMP_W-1:0]                  hdl_ext;
    logic [CMP_W-1:0]                  dl_ext;
    logic [CMP_W-1:0]                  head_ext;
    logic                              hdl_fits;
    logic                              table_full;
    logic                              head_due;
    logic                              next_due;

    assign accept = start && !busy;

    // Widen handle and deadlines to a common width for compare and report.
    assign hdl_ext  = CMP_W'(hdl_reg);
    assign dl_ext   = CMP_W'(dl_reg);
    assign head_ext = CMP_W'(c_deadline[0]);
    assign hdl_fits = ((hdl_ext >> TIME_BITS) == '0);

    assign table_full = c_valid[TABLE_DEPTH-1];
    assign head_due   = c_valid[0] && (c_deadline[0] <= now_reg);
    assign next_due   = c_valid[1] && (c_deadline[1] <= now_reg);

    // Key presented to the cells: the new deadline or the stop handle.
    assign key_deadline = (op_reg == dtq_pkg::OP_STOP) ? hdl_ext[TIME_BITS-1:0] : dl_reg;

    // Sequencer: next state, cell command and result.
    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        now_next    = now_reg;
        dl_next     = dl_reg;
        own_next    = own_reg;
        dat_next    = dat_reg;
        hdl_next    = hdl_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        rhdl_next   = rhdl_reg;
        rown_next   = rown_reg;
        rdat_next   = rdat_reg;
        last_next   = last_reg;
        ctrl.op       = dtq_pkg::CELL_HOLD;
        ctrl.key_fits = hdl_fits;

        case (state_reg)
            dtq_pkg::S_IDLE:
            begin
                if (accept) begin
                    op_next  = operation;
                    own_next = owner_id;
                    dat_next = app_data;
                    hdl_next = handle;
                    dl_next  = now_reg + TIME_BITS'(delay_ms);
                    cnt_next = '0;
                    case (operation)
                        dtq_pkg::OP_START, dtq_pkg::OP_STOP:
                        begin
                            state_next = dtq_pkg::S_EXEC;
                        end
                        dtq_pkg::OP_TICK:
                        begin
                            now_next   = now_reg + TIME_BITS'(1);
                            state_next = dtq_pkg::S_POP;
                        end
                        default:
                        begin
                            state_next = dtq_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            dtq_pkg::S_EXEC:
            begin
                done_next  = 1'b1;
                last_next  = 1'b1;
                rown_next  = own_reg;
                rdat_next  = '0;
                state_next = dtq_pkg::S_IDLE;
                if (op_reg == dtq_pkg::OP_START) begin
                    if (table_full) begin
                        status_next = dtq_pkg::ST_FULL;
                        rhdl_next   = '0;
                    end else begin
                        ctrl.op     = dtq_pkg::CELL_INSERT;
                        status_next = dtq_pkg::ST_STARTED;
                        rhdl_next   = dl_ext[dtq_pkg::HANDLE_W-1:0];
                    end
                end else begin
                    ctrl.op     = dtq_pkg::CELL_REMOVE;
                    status_next = seen_chain[TABLE_DEPTH] ? dtq_pkg::ST_STOPPED
                                                          : dtq_pkg::ST_NOT_FOUND;
                    rhdl_next   = hdl_reg;
                end
            end
            dtq_pkg::S_POP:
            begin
                if (head_due) begin
                    ctrl.op     = dtq_pkg::CELL_POP;
                    done_next   = 1'b1;
                    status_next = dtq_pkg::ST_FIRED;
                    rhdl_next   = head_ext[dtq_pkg::HANDLE_W-1:0];
                    rown_next   = c_owner[0];
                    rdat_next   = c_data[0];
                    last_next   = !next_due ||
                                  (cnt_reg == dtq_pkg::CNT_W'(dtq_pkg::MAX_RESULTS - 1));
                    cnt_next    = cnt_reg + dtq_pkg::CNT_W'(1);
                    if (last_next) begin
                        state_next = dtq_pkg::S_IDLE;
                    end
                end else begin
                    state_next = dtq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dtq_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= dtq_pkg::S_IDLE;
            now_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            now_reg   <= now_next;
            done_reg  <= done_next;
        end
    end

    // Command and result payload registers.
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        dl_reg     <= dl_next;
        own_reg    <= own_next;
        dat_reg    <= dat_next;
        hdl_reg    <= hdl_next;
        cnt_reg    <= cnt_next;
        status_reg <= status_next;
        rhdl_reg   <= rhdl_next;
        rown_reg   <= rown_next;
        rdat_reg   <= rdat_next;
        last_reg   <= last_next;
    end

    // Chain ends: the first cell inserts whenever it does not keep its entry,
    // and no stop hit comes from before the first cell.
    assign keep_chain[0] = 1'b1;
    assign seen_chain[0] = 1'b0;

    // Row of cells, each wired to its two neighbours.
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        logic                              lv, rv;
        logic [TIME_BITS-1:0]              ld, rd;
        logic [dtq_pkg::OWNER_W-1:0]       lo, ro;
        logic signed [dtq_pkg::DATA_W-1:0] la, ra;

        if (i == 0) begin : g_left_end
            assign lv = 1'b0;
            assign ld = '0;
            assign lo = '0;
            assign la = '0;
        end else begin : g_left
            assign lv = c_valid[i-1];
            assign ld = c_deadline[i-1];
            assign lo = c_owner[i-1];
            assign la = c_data[i-1];
        end

        if (i == TABLE_DEPTH - 1) begin : g_right_end
            assign rv = 1'b0;
            assign rd = '0;
            assign ro = '0;
            assign ra = '0;
        end else begin : g_right
            assign rv = c_valid[i+1];
            assign rd = c_deadline[i+1];
            assign ro = c_owner[i+1];
            assign ra = c_data[i+1];
        end

        dtq_cell #(
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .ctrl           (ctrl),
            .key_deadline   (key_deadline),
            .key_owner      (own_reg),
            .key_data       (dat_reg),
            .left_valid     (lv),
            .left_deadline  (ld),
            .left_owner     (lo),
            .left_data      (la),
            .left_keep      (keep_chain[i]),
            .right_valid    (rv),
            .right_deadline (rd),
            .right_owner    (ro),
            .right_data     (ra),
            .seen_in        (seen_chain[i]),
            .valid          (c_valid[i]),
            .deadline       (c_deadline[i]),
            .owner          (c_owner[i]),
            .data           (c_data[i]),
            .keep           (keep_chain[i+1]),
            .seen_out       (seen_chain[i+1])
        );
    end

    // Outputs.
    assign busy          = (state_reg != dtq_pkg::S_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign result_handle = rhdl_reg;
    assign fired_owner   = rown_reg;
    assign fired_data    = rdat_reg;
    assign last          = last_reg;

endmodule
